// File: rtl/core/bpsd_pkg.sv
//==============================================================================
// Byte-pair stream decoder package
// Phase codes, result status codes and stream constants.
//==============================================================================
`default_nettype none

package bpsd_pkg;

   typedef enum logic [3:0] {
      PH_MAGIC,
      PH_FLAG,
      PH_SIZE,
      PH_BLOCK,
      PH_CTRL,
      PH_ENTRY,
      PH_COUNT,
      PH_CODES,
      PH_IDLE,
      PH_EXPAND,
      PH_RESET_TBL,
      PH_SEND
   } phase_type;

   typedef enum logic [2:0] {
      ST_DATA      = 3'd0,
      ST_COMPLETE  = 3'd1,
      ST_SHORT     = 3'd2,
      ST_BAD_MAGIC = 3'd3,
      ST_SIZE      = 3'd4,
      ST_TRUNC     = 3'd5,
      ST_OVERRUN   = 3'd6,
      ST_OVERFLOW  = 3'd7
   } status_type;

   localparam logic [31:0] STREAM_MAGIC = 32'hFF43_5031;
   localparam logic [7:0]  RUN_LIMIT    = 8'h7F;
   localparam int unsigned PAIR_ENTRIES = 256;
   localparam int unsigned RESULT_CAP   = 64;

endpackage

`default_nettype wire

// File: rtl/core/byte_pair_stream_decoder_top.sv
//==============================================================================
// Byte-pair stream decoder
// Parses the stream header and blocks, keeps the pair table and the expansion
// stack in RAMs, and expands codes depth first into output bytes.
//==============================================================================
// Header, table and count bytes are taken one per cycle while the result side is free.
// While a code byte expands the input is held; the expansion visits each literal
// and each pair, with one RAM read per stack pop.
// The first byte of each block holds the input during an identity reload of all
// 256 left-pair table entries, and is then taken as the control byte.
// Results are registered; reset is synchronous, RAMs are not cleared.
`default_nettype none

module byte_pair_stream_decoder_top #(
   parameter int STACK_DEPTH = 256,
   parameter int MAX_EXPAND  = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_first,
   input  wire logic        req_in_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic [2:0]       rsp_out_status,
   output logic             rsp_out_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import bpsd_pkg::*;

   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int BUDGET = (MAX_EXPAND < RESULT_CAP - 1) ? MAX_EXPAND : RESULT_CAP - 1;
   localparam logic [6:0] BUDGET_C = 7'(BUDGET);

   // Configuration register.
   logic [31:0] expected_size_ff;
   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? expected_size_ff : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_size_ff <= '0;
      end else if (psel && penable && pwrite && paddr == 2'd0) begin
         expected_size_ff <= pwdata;
      end
   end

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [31:0] shift_ff, shift_in;
   logic [2:0]  fcnt_ff, fcnt_in;
   logic        short_ff, short_in;
   logic [8:0]  tidx_ff, tidx_in;
   logic [7:0]  run_ff, run_in;
   logic        await_ff, await_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [31:0] codes_ff, codes_in;
   logic [31:0] emitted_ff, emitted_in;
   logic [6:0]  made_ff, made_in;
   logic        pend_ff, pend_in;      // pop read is in flight
   logic [7:0]  x_ff, x_in;            // symbol being expanded (code, left half or pop)
   logic        xval_ff, xval_in;      // symbol waits for table read
   logic        last_ff, last_in;      // in_last of the code being expanded or of the held block byte
   logic        rst_tbl_ff, rst_tbl_in;// byte waiting behind the table reset
   logic [7:0]  hold_ff, hold_in;
   logic [8:0]  clr_ff, clr_in;
   logic [2:0]  ost_ff, ost_in;        // deferred closing status

   // Output register.
   logic        ov_ff, ov_in;
   logic [7:0]  ob_ff, ob_in;
   logic [2:0]  os_ff, os_in;
   logic        ol_ff, ol_in;
   assign rsp_valid      = ov_ff;
   assign rsp_out_byte   = ob_ff;
   assign rsp_out_status = os_ff;
   assign rsp_out_last   = ol_ff;
   wire out_free = !ov_ff || rsp_ready;

   // RAM ports.
   logic        lw_en, rw_en, sw_en;
   logic [7:0]  lw_addr, lw_data, rw_data, l_raddr, l_rdata, r_rdata;
   logic [SAW-1:0] sw_addr, s_raddr;
   logic [7:0]  sw_data, s_rdata;

   bpsd_ram #(.WIDTH(8), .DEPTH(256)) u_left (
      .clock, .wr_en(lw_en), .wr_addr(lw_addr), .wr_data(lw_data),
      .rd_addr(l_raddr), .rd_data(l_rdata));
   bpsd_ram #(.WIDTH(8), .DEPTH(256)) u_right (
      .clock, .wr_en(rw_en), .wr_addr(lw_addr), .wr_data(rw_data),
      .rd_addr(l_raddr), .rd_data(r_rdata));
   bpsd_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock, .wr_en(sw_en), .wr_addr(sw_addr), .wr_data(sw_data),
      .rd_addr(s_raddr), .rd_data(s_rdata));

   // The input is closed during expansion, table reload, a pending status and
   // the replay of the byte that opened the block.
   wire busy = phase_ff == PH_EXPAND || phase_ff == PH_RESET_TBL || phase_ff == PH_SEND
               || rst_tbl_ff;
   assign req_ready = !busy && out_free;
   wire acc = req_valid && req_ready;

   // Next state.
   always_comb begin
      phase_type ph;
      logic [31:0] sh, em;
      logic [2:0]  fc;
      logic [8:0]  ti, tsum;
      logic [7:0]  b, rr, d;
      logic        lst, err, fin;
      logic [2:0]  est;
      phase_in = phase_ff;  shift_in = shift_ff;  fcnt_in = fcnt_ff;
      short_in = short_ff;  tidx_in = tidx_ff; run_in = run_ff;     await_in = await_ff;
      sp_in = sp_ff;        codes_in = codes_ff; emitted_in = emitted_ff;
      made_in = made_ff;    pend_in = 1'b0;   x_in = x_ff;          xval_in = 1'b0;
      last_in = last_ff;    rst_tbl_in = rst_tbl_ff; hold_in = hold_ff;
      clr_in = clr_ff;      ost_in = ost_ff;
      ov_in = ov_ff && !rsp_ready; ob_in = ob_ff; os_in = os_ff; ol_in = ol_ff;
      lw_en = 1'b0; rw_en = 1'b0; sw_en = 1'b0;
      lw_addr = tidx_ff[7:0]; lw_data = 8'd0; rw_data = 8'd0;
      l_raddr = s_rdata; sw_addr = '0; sw_data = 8'd0; s_raddr = '0;
      ph = phase_ff; sh = shift_ff; fc = fcnt_ff; ti = tidx_ff; rr = run_ff;
      b = req_in_byte; lst = req_in_last; err = 1'b0; est = ST_DATA; fin = 1'b0;
      em = emitted_ff + 32'd1; d = tidx_ff[7:0]; tsum = '0;

      unique case (phase_ff)
         // Identity reload of the left table, one entry a cycle.
         PH_RESET_TBL: begin
            lw_en = 1'b1; lw_addr = clr_ff[7:0]; lw_data = clr_ff[7:0];
            clr_in = clr_ff + 9'd1;
            if (clr_ff == 9'd255) begin
               phase_in = PH_CTRL;
               tidx_in = '0;
            end
         end
         // Pending closing result after expansion.
         PH_SEND: begin
            if (out_free) begin
               ov_in = 1'b1; ob_in = 8'd0; os_in = ost_ff; ol_in = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         // Depth-first expansion: pop read, then table read, then act.
         PH_EXPAND: begin
            if (xval_ff) begin
               if (l_rdata == x_ff) begin
                  if (out_free) begin
                     if (made_ff >= BUDGET_C) begin
                        ov_in = 1'b1; ob_in = 8'd0; os_in = ST_OVERFLOW; ol_in = 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        made_in = made_ff + 7'd1;
                        emitted_in = em;
                        ov_in = 1'b1; ob_in = x_ff; ol_in = 1'b0;
                        if (em == expected_size_ff) begin
                           os_in = ST_COMPLETE; ol_in = 1'b1; phase_in = PH_IDLE;
                        end else begin
                           os_in = ST_DATA;
                           if (sp_ff == '0) begin
                              // Code done.
                              ph = (codes_ff == 32'd0) ? PH_BLOCK : PH_CODES;
                              if (last_ff) begin
                                 ost_in = (ph == PH_BLOCK) ? ST_SHORT : ST_TRUNC;
                                 phase_in = PH_SEND;
                              end else begin
                                 ol_in = 1'b1; phase_in = ph;
                              end
                           end else begin
                              s_raddr = SAW'(sp_ff - SPW'(1));
                              sp_in = sp_ff - SPW'(1);
                              pend_in = 1'b1;
                           end
                        end
                     end
                  end else begin
                     xval_in = 1'b1; l_raddr = x_ff;
                  end
               end else if ({1'b0, sp_ff} + (SPW+1)'(2) > (SPW+1)'(STACK_DEPTH)) begin
                  ost_in = ST_OVERFLOW; phase_in = PH_SEND;
               end else begin
                  // Push right; left is expanded next, kept directly without a push.
                  sw_en = 1'b1; sw_addr = SAW'(sp_ff); sw_data = r_rdata;
                  sp_in = sp_ff + SPW'(1);
                  x_in = l_rdata; xval_in = 1'b1; l_raddr = l_rdata;
               end
            end else if (pend_ff) begin
               x_in = s_rdata; xval_in = 1'b1; l_raddr = s_rdata;
            end
         end
         default: begin
            if (acc) begin
               if (req_in_first) begin
                  ph = PH_MAGIC; sh = '0; fc = '0; short_in = 1'b0; ti = '0; rr = '0;
                  await_in = 1'b0; sp_in = '0; codes_in = '0; emitted_in = '0;
               end
               phase_in = ph; shift_in = sh; fcnt_in = fc; tidx_in = ti; run_in = rr;
               d = ti[7:0];
               unique case (ph)
                  PH_MAGIC: begin
                     if (b != STREAM_MAGIC[8*fc[1:0] +: 8]) begin
                        err = 1'b1; est = ST_BAD_MAGIC;
                     end else if (fc == 3'd3) begin
                        phase_in = PH_FLAG; fcnt_in = '0; shift_in = '0;
                     end else fcnt_in = fc + 3'd1;
                  end
                  PH_FLAG, PH_SIZE, PH_COUNT: begin
                     sh = sh | (32'(b) << (8 * fc[1:0]));
                     shift_in = sh; fcnt_in = fc + 3'd1;
                     if (ph == PH_FLAG && fc == 3'd3) begin
                        short_in = sh != 32'd0; phase_in = PH_SIZE;
                        fcnt_in = '0; shift_in = '0;
                     end else if (ph == PH_SIZE && fc == 3'd3) begin
                        if (sh != expected_size_ff) begin
                           err = 1'b1; est = ST_SIZE;
                        end else phase_in = (sh == 32'd0) ? PH_IDLE : PH_BLOCK;
                     end else if (ph == PH_COUNT &&
                                  fc == (short_ff ? 3'd1 : 3'd3)) begin
                        codes_in = sh;
                        phase_in = (sh == 32'd0) ? PH_BLOCK : PH_CODES;
                     end
                  end
                  PH_BLOCK: begin
                     // Reload identity first, then take this byte as control.
                     rst_tbl_in = 1'b1; hold_in = b; last_in = lst;
                     clr_in = '0; phase_in = PH_RESET_TBL;
                  end
                  PH_CTRL: begin
                     if (b > RUN_LIMIT) begin
                        tsum = ti + 9'(b - RUN_LIMIT);
                        if (tsum[8] || ti[8]) begin
                           tidx_in = 9'd256; phase_in = PH_COUNT;
                           shift_in = '0; fcnt_in = '0;
                        end else begin
                           tidx_in = tsum; run_in = 8'd1; await_in = 1'b0;
                           phase_in = PH_ENTRY;
                        end
                     end else begin
                        run_in = b + 8'd1; await_in = 1'b0; phase_in = PH_ENTRY;
                     end
                  end
                  PH_ENTRY: begin
                     lw_addr = d;
                     if (await_ff) begin
                        rw_en = 1'b1; rw_data = b; fin = 1'b1;
                     end else begin
                        lw_en = 1'b1; lw_data = b;
                        if (b != d) await_in = 1'b1;
                        else fin = 1'b1;
                     end
                     if (fin) begin
                        await_in = 1'b0;
                        tidx_in = ti + 9'd1;
                        run_in = rr - 8'd1;
                        if (rr != 8'd1) begin
                           if (ti == 9'd255) begin
                              err = 1'b1; est = ST_OVERRUN;
                           end
                        end else if (ti == 9'd255) begin
                           phase_in = PH_COUNT; shift_in = '0; fcnt_in = '0;
                        end else phase_in = PH_CTRL;
                     end
                  end
                  PH_CODES: begin
                     codes_in = codes_ff - 32'd1;
                     sp_in = '0; made_in = '0; last_in = lst;
                     x_in = b; xval_in = 1'b1; l_raddr = b;
                     phase_in = PH_EXPAND;
                  end
                  default: ;
               endcase
               if (err) begin
                  ov_in = 1'b1; ob_in = 8'd0; os_in = est; ol_in = 1'b1;
                  phase_in = PH_IDLE;
               end else if (lst && phase_in != PH_IDLE && phase_in != PH_EXPAND
                            && phase_in != PH_RESET_TBL) begin
                  ov_in = 1'b1; ob_in = 8'd0; ol_in = 1'b1;
                  os_in = (phase_in == PH_BLOCK) ? ST_SHORT : ST_TRUNC;
                  phase_in = PH_IDLE;
               end
            end else if (rst_tbl_ff && phase_ff == PH_CTRL && out_free) begin
               // Replay the byte that opened the block as its control byte.
               rst_tbl_in = 1'b0;
               b = hold_ff;
               if (b > RUN_LIMIT) begin
                  tsum = 9'(b - RUN_LIMIT);
                  tidx_in = tsum; run_in = 8'd1; await_in = 1'b0;
                  phase_in = PH_ENTRY;
               end else begin
                  tidx_in = '0; run_in = b + 8'd1; await_in = 1'b0;
                  phase_in = PH_ENTRY;
               end
               if (last_ff) begin
                  ov_in = 1'b1; ob_in = 8'd0; ol_in = 1'b1; os_in = ST_TRUNC;
                  phase_in = PH_IDLE;
               end
            end
         end
      endcase
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC; shift_ff <= '0; fcnt_ff <= '0;
         short_ff <= 1'b0; tidx_ff <= '0; run_ff <= '0; await_ff <= 1'b0;
         sp_ff <= '0; codes_ff <= '0; emitted_ff <= '0; made_ff <= '0;
         pend_ff <= 1'b0; xval_ff <= 1'b0; last_ff <= 1'b0; rst_tbl_ff <= 1'b0;
         clr_ff <= '0; ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; shift_ff <= shift_in;
         fcnt_ff <= fcnt_in; short_ff <= short_in; tidx_ff <= tidx_in;
         run_ff <= run_in; await_ff <= await_in; sp_ff <= sp_in;
         codes_ff <= codes_in; emitted_ff <= emitted_in; made_ff <= made_in;
         pend_ff <= pend_in; xval_ff <= xval_in; last_ff <= last_in;
         rst_tbl_ff <= rst_tbl_in; clr_ff <= clr_in;
         ov_ff <= ov_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      x_ff <= x_in; hold_ff <= hold_in; ost_ff <= ost_in;
      ob_ff <= ob_in; os_ff <= os_in; ol_ff <= ol_in;
   end

   // Checks.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready) else $error("item accepted while busy");
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
   a_budget: assert property (@(posedge clock) disable iff (reset)
      made_ff <= BUDGET_C) else $error("expansion budget exceeded");
   a_pend_only_expand: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> phase_ff == PH_EXPAND) else $error("pop outside expansion");

endmodule

`default_nettype wire

// File: rtl/core/bpsd_ram.sv
//==============================================================================
// Generic RAM
// Single write port, single read port, registered read data.
//==============================================================================
`default_nettype none

module bpsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire
